FILE: hdl/lpht_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the linear-probe hash table core.
// Used by lpht_slot_mem and linear_probe_hash_table_core; no dependencies.

package lpht_pkg;

    localparam int SLOTS       = 64;               // power of two, 2..4096
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int PROBE_CNT_W = $clog2(SLOTS + 1);
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 7;                // entry count, wraps mod 128

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_type_t;

    // slot memory write port
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_wr_t;

endpackage

FILE: hdl/lpht_slot_mem.sv
`timescale 1ns / 1ps
// Key/value slot storage: one write port, one registered read port.
// Depends on lpht_pkg.

module lpht_slot_mem (
    input  logic                          aclk,
    input  lpht_pkg::slot_wr_t            wr,
    input  logic [lpht_pkg::IDX_W-1:0]    rd_addr,
    output logic [lpht_pkg::KEY_W-1:0]    rd_key,
    output logic [lpht_pkg::VALUE_W-1:0]  rd_value
);

    logic [lpht_pkg::KEY_W-1:0]   key_mem   [lpht_pkg::SLOTS];
    logic [lpht_pkg::VALUE_W-1:0] value_mem [lpht_pkg::SLOTS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            key_mem[wr.addr]   <= wr.key;
            value_mem[wr.addr] <= wr.value;
        end
        rd_key   <= key_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
    end

endmodule

FILE: hdl/linear_probe_hash_table_core.sv
`timescale 1ns / 1ps
// Top level of the linear-probe hash table: request sequencer, used bits, count.
// Depends on lpht_pkg and lpht_slot_mem.
//
// Usage:
//  - Request channel s_*: s_tuser carries the request type (insert, lookup,
//    remove, clear); s_tdata carries key and insert value.
//  - Result channel m_*: one result per request. m_tuser is the success flag,
//    m_tdata carries the looked-up value (zero otherwise) and the entry count.
//  - s_tready is high only while the sequencer is idle; one request at a time.
//  - A probe walks the slots from the home slot (key low bits) with wraparound,
//    one slot read per cycle from the slot memory; the compare runs in the
//    cycle after the read. A request that stops at a probe goes to its result
//    state; one that probes every slot without stopping ends as a miss, and
//    clear goes straight to the result state. The next request is taken in the
//    cycle after the result is loaded, so a full probe occupies the block
//    until then. The single memory read port sets the pace of the probe walk.
//  - The result sits in an output register; the next request may be accepted
//    while it waits. A stalled receiver holds the sequencer in its result
//    state once a second result is ready.
//  - Reset frees every slot (used bits in flops) and zeroes the count; no
//    memory clearing pass is needed.

module linear_probe_hash_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    // request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] data_in
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data_out, [38:32] entry_count, [39] zero
    output logic        m_tuser    // [0] ok
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_RESULT
    } state_t;

    state_t                              state_reg;
    lpht_pkg::req_type_t                 req_reg;
    logic [lpht_pkg::KEY_W-1:0]          key_reg;
    logic [lpht_pkg::VALUE_W-1:0]        value_reg;
    logic [lpht_pkg::SLOTS-1:0]          used_reg;
    logic [lpht_pkg::COUNT_W-1:0]        count_reg;
    logic [lpht_pkg::IDX_W-1:0]          issue_pos_reg;
    logic [lpht_pkg::PROBE_CNT_W-1:0]    issue_cnt_reg;
    logic                                rd_vld_reg;
    logic [lpht_pkg::IDX_W-1:0]          rd_pos_reg;
    logic                                ok_reg;
    logic [lpht_pkg::VALUE_W-1:0]        dout_reg;
    logic                                m_tvalid_reg;
    logic                                m_ok_reg;
    logic [lpht_pkg::VALUE_W-1:0]        m_dout_reg;
    logic [lpht_pkg::COUNT_W-1:0]        m_count_reg;

    logic [lpht_pkg::KEY_W-1:0]          rd_key;
    logic [lpht_pkg::VALUE_W-1:0]        rd_value;
    lpht_pkg::slot_wr_t                  slot_wr;

    logic slot_used;
    logic key_match;
    logic probe_take;
    logic issue_more;
    logic probe_miss;
    logic result_load;

    // compare stage: one slot per cycle, read data arrives in the cycle after the issue
    assign slot_used  = used_reg[rd_pos_reg];
    assign key_match  = slot_used && (rd_key == key_reg);
    assign probe_take = rd_vld_reg &&
                        (key_match || (req_reg == lpht_pkg::REQ_INSERT && !slot_used));
    assign issue_more = (state_reg == ST_PROBE) &&
                        (issue_cnt_reg < lpht_pkg::PROBE_CNT_W'(lpht_pkg::SLOTS));
    assign probe_miss = !rd_vld_reg &&
                        (issue_cnt_reg == lpht_pkg::PROBE_CNT_W'(lpht_pkg::SLOTS));

    // output register takes a new result when empty or being drained
    assign result_load = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);

    // insert writes key and value at the slot it settles on
    always_comb begin
        slot_wr.en    = (state_reg == ST_PROBE) && probe_take &&
                        (req_reg == lpht_pkg::REQ_INSERT);
        slot_wr.addr  = rd_pos_reg;
        slot_wr.key   = key_reg;
        slot_wr.value = value_reg;
    end

    lpht_slot_mem u_slot_mem (
        .aclk     (aclk),
        .wr       (slot_wr),
        .rd_addr  (issue_pos_reg),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_dout_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (result_load) begin
                m_tvalid_reg <= 1'b1;
                m_ok_reg     <= ok_reg;
                m_dout_reg   <= dout_reg;
                m_count_reg  <= count_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    rd_vld_reg <= 1'b0;
                    if (s_tvalid) begin
                        req_reg       <= lpht_pkg::req_type_t'(s_tuser);
                        key_reg       <= s_tdata[31:0];
                        value_reg     <= s_tdata[63:32];
                        issue_pos_reg <= s_tdata[lpht_pkg::IDX_W-1:0];
                        issue_cnt_reg <= '0;
                        dout_reg      <= '0;
                        if (lpht_pkg::req_type_t'(s_tuser) == lpht_pkg::REQ_CLEAR) begin
                            used_reg  <= '0;
                            count_reg <= '0;
                            ok_reg    <= 1'b1;
                            state_reg <= ST_RESULT;
                        end else begin
                            ok_reg    <= 1'b0;
                            state_reg <= ST_PROBE;
                        end
                    end
                end

                ST_PROBE: begin
                    rd_vld_reg <= issue_more && !probe_take;
                    rd_pos_reg <= issue_pos_reg;
                    if (issue_more) begin
                        issue_pos_reg <= issue_pos_reg + 1'b1;   // wraps at SLOTS
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                    if (probe_take) begin
                        ok_reg     <= 1'b1;
                        state_reg  <= ST_RESULT;
                        case (req_reg)
                            lpht_pkg::REQ_INSERT: begin
                                if (!slot_used) begin
                                    used_reg[rd_pos_reg] <= 1'b1;
                                    count_reg            <= count_reg + 1'b1;
                                end
                            end
                            lpht_pkg::REQ_LOOKUP: begin
                                dout_reg <= rd_value;
                            end
                            lpht_pkg::REQ_REMOVE: begin
                                used_reg[rd_pos_reg] <= 1'b0;
                                count_reg            <= count_reg - 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end else if (probe_miss) begin
                        state_reg <= ST_RESULT;
                    end
                end

                ST_RESULT: begin
                    if (result_load) begin
                        state_reg <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
